[rtl/tsc_pkg.sv]
// Shared types and constants for the per-token slice copy descriptor unit.
// Used by every RTL file of the block; depends on nothing.
package tsc_pkg;

  // Block geometry and offset range
  localparam int unsigned MaxTokensPerBlock = 64;
  localparam int unsigned OffsetWidth       = 48;

  // Field widths fixed by the interface
  localparam int unsigned TokW   = 32;  // token positions, counts, block numbers
  localparam int unsigned BytesW = 20;  // per-token byte sizes, slice length
  localparam int unsigned TpbW   = 7;   // tokens_per_block register
  localparam int unsigned GrpW   = 8;   // group_offset register
  localparam int unsigned ModeW  = 2;
  localparam int unsigned OutW   = 48;  // descriptor offsets, capacities
  localparam int unsigned CfgW   = 48;  // widest register
  localparam int unsigned CfgIdxW = 3;

  // Token index inside a block, 0..MaxTokensPerBlock
  localparam int unsigned CntW = $clog2(MaxTokensPerBlock + 1);

  // Shared multiplier operands (32 x 27) and accumulator width
  localparam int unsigned MulAW = TokW;
  localparam int unsigned MulBW = BytesW + CntW;
  localparam int unsigned AccW  = TokW + BytesW + CntW + 1;
  localparam int unsigned SumW  = AccW + 1;

  // Largest offset that fits in OffsetWidth bits
  localparam logic [SumW-1:0] OffMask = (OffsetWidth >= SumW) ? {SumW{1'b1}} :
                                        SumW'((65'd1 << OffsetWidth) - 65'd1);

  // Divider step counter
  localparam int unsigned DivStepW = $clog2(TokW);

  // Mode register bits
  localparam int unsigned ModeSwapBit = 0;
  localparam int unsigned ModeHalfBit = 1;

  typedef enum logic {
    ReqStart = 1'b0,
    ReqBlock = 1'b1
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSrcTokenBytes  = 3'd0,
    CfgSrcSliceBytes  = 3'd1,
    CfgDstTokenBytes  = 3'd2,
    CfgTokensPerBlock = 3'd3,
    CfgGroupOffset    = 3'd4,
    CfgMode           = 3'd5,
    CfgSrcCapacity    = 3'd6,
    CfgDstCapacity    = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_MATCH,
    S_SRC_A,
    S_SRC_B,
    S_DST_A,
    S_DST_B,
    S_SOFF,
    S_DOFF,
    S_GRP,
    S_FIN,
    S_EMIT
  } state_e;

  // One step of the shared multiplier sequence
  typedef enum logic [3:0] {
    MS_NONE,
    MS_SRC_A,   // src token bytes * tokens per block
    MS_SRC_B,   // * src block number
    MS_DST_A,   // keep src base, dst token bytes * tokens per block
    MS_DST_B,   // * dst block number
    MS_SOFF,    // keep dst base, first token * src token bytes
    MS_DOFF,    // add to src, first token * dst token bytes
    MS_GRP,     // add to dst, group offset * slice
    MS_FIN      // add to dst, latch descriptor count
  } mul_step_e;

  typedef struct packed {
    logic      load_start;
    logic      load_block;
    logic      div_start;
    mul_step_e step;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic div_ok;
    logic div_done;
    logic idx_match;
    logic out_free;
    logic last_beat;
  } status_t;

endpackage

[rtl/tsc_if.sv]
// Valid/ready channel interfaces: request items in, copy descriptors out.
// Field widths come from tsc_pkg.
interface tsc_req_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [tsc_pkg::TokW-1:0] start_token;
  logic [tsc_pkg::TokW-1:0] token_count;
  logic [tsc_pkg::TokW-1:0] block_index;
  logic [tsc_pkg::TokW-1:0] src_block_number;
  logic [tsc_pkg::TokW-1:0] dst_block_number;

  modport source (
    output valid, req_type, start_token, token_count, block_index,
           src_block_number, dst_block_number,
    input  ready
  );
  modport sink (
    input  valid, req_type, start_token, token_count, block_index,
           src_block_number, dst_block_number,
    output ready
  );
endinterface

interface tsc_desc_if;
  logic                       valid;
  logic                       ready;
  logic [tsc_pkg::OutW-1:0]   copy_src_offset;
  logic [tsc_pkg::OutW-1:0]   copy_dst_offset;
  logic [tsc_pkg::BytesW-1:0] copy_length;
  logic                       out_of_bounds;
  logic                       last;

  modport source (
    output valid, copy_src_offset, copy_dst_offset, copy_length, out_of_bounds, last,
    input  ready
  );
  modport sink (
    input  valid, copy_src_offset, copy_dst_offset, copy_length, out_of_bounds, last,
    output ready
  );
endinterface

[rtl/tsc_div.sv]
// Restoring divider, one quotient bit per cycle: token position / tokens per block.
// Depends on tsc_pkg.
module tsc_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [tsc_pkg::TokW-1:0] dividend_i,
  input  logic [tsc_pkg::CntW-1:0] divisor_i,
  output logic [tsc_pkg::TokW-1:0] quotient_o,
  output logic [tsc_pkg::CntW-1:0] remainder_o,
  output logic                     done_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [tsc_pkg::DivStepW-1:0] step_q;
  logic [tsc_pkg::TokW-1:0]     dvd_q;
  logic [tsc_pkg::CntW-1:0]     rem_q;
  logic [tsc_pkg::CntW:0]       trial;
  logic                         ge;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem_q, dvd_q[tsc_pkg::TokW-1]};
  assign ge    = (trial >= {1'b0, divisor_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient bits replace dividend bits as they shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[tsc_pkg::TokW-2:0], ge};
      rem_q <= ge ? tsc_pkg::CntW'(trial - {1'b0, divisor_i})
                  : tsc_pkg::CntW'(trial);
    end
  end

  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

  // Done is a single-cycle pulse at the end of a pass
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held for more than one cycle");

endmodule

[rtl/tsc_dp.sv]
// Datapath: configuration registers, request state, shared multiplier,
// offset accumulators, bounds check and descriptor output register.
// Depends on tsc_pkg and tsc_div.
module tsc_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tsc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tsc_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [tsc_pkg::TokW-1:0]    start_token_i,
  input  logic [tsc_pkg::TokW-1:0]    token_count_i,
  input  logic [tsc_pkg::TokW-1:0]    block_index_i,
  input  logic [tsc_pkg::TokW-1:0]    src_block_number_i,
  input  logic [tsc_pkg::TokW-1:0]    dst_block_number_i,
  input  tsc_pkg::cmd_t               cmd_i,
  output tsc_pkg::status_t            status_o,
  input  logic                        desc_ready_i,
  output logic                        desc_valid_o,
  output logic [tsc_pkg::OutW-1:0]    copy_src_offset_o,
  output logic [tsc_pkg::OutW-1:0]    copy_dst_offset_o,
  output logic [tsc_pkg::BytesW-1:0]  copy_length_o,
  output logic                        out_of_bounds_o,
  output logic                        last_o
);

  // Configuration registers
  logic [tsc_pkg::BytesW-1:0] stb_q, ssb_q, dtb_q;
  logic [tsc_pkg::TpbW-1:0]   tpb_q;
  logic [tsc_pkg::GrpW-1:0]   grp_q;
  logic [tsc_pkg::ModeW-1:0]  mode_q;
  logic [tsc_pkg::OutW-1:0]   src_cap_q, dst_cap_q;

  // Request state and cached block split of the position
  logic [tsc_pkg::TokW-1:0] pos_q, rem_q, quo_q;
  logic [tsc_pkg::CntW-1:0] base_q;
  logic                     div_ok_q;

  // Captured block item
  logic [tsc_pkg::TokW-1:0] blk_idx_q, sbn_q, dbn_q;

  // Multiplier and accumulators
  logic [tsc_pkg::AccW-1:0]              p_q, sacc_q, dacc_q;
  logic [tsc_pkg::MulAW-1:0]             mul_a;
  logic [tsc_pkg::MulBW-1:0]             mul_b;
  logic [tsc_pkg::MulAW+tsc_pkg::MulBW-1:0] mul_full;

  // Descriptor counts
  logic [tsc_pkg::CntW-1:0] left_q, cnt_q, avail, count;
  logic                     full_q;
  logic [tsc_pkg::CntW-1:0] tpb_eff;
  logic [tsc_pkg::BytesW-1:0] slice;

  // Output register
  logic                       out_valid_q;
  logic [tsc_pkg::OutW-1:0]   out_src_q, out_dst_q;
  logic [tsc_pkg::BytesW-1:0] out_len_q;
  logic                       out_oob_q, out_last_q;

  // Emit path
  logic [tsc_pkg::AccW-1:0] so, dof;
  logic [tsc_pkg::SumW-1:0] se, de;
  logic                     oob;
  logic                     commit;
  logic [tsc_pkg::TokW:0]   pos_sum;

  // Divider outputs
  logic [tsc_pkg::TokW-1:0] div_quo;
  logic [tsc_pkg::CntW-1:0] div_rem;
  logic                     div_done;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stb_q     <= tsc_pkg::BytesW'(1);
      ssb_q     <= tsc_pkg::BytesW'(1);
      dtb_q     <= tsc_pkg::BytesW'(1);
      tpb_q     <= tsc_pkg::TpbW'(16);
      grp_q     <= '0;
      mode_q    <= '0;
      src_cap_q <= '0;
      dst_cap_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tsc_pkg::CfgSrcTokenBytes:  stb_q     <= cfg_data_i[tsc_pkg::BytesW-1:0];
        tsc_pkg::CfgSrcSliceBytes:  ssb_q     <= cfg_data_i[tsc_pkg::BytesW-1:0];
        tsc_pkg::CfgDstTokenBytes:  dtb_q     <= cfg_data_i[tsc_pkg::BytesW-1:0];
        tsc_pkg::CfgTokensPerBlock: tpb_q     <= cfg_data_i[tsc_pkg::TpbW-1:0];
        tsc_pkg::CfgGroupOffset:    grp_q     <= cfg_data_i[tsc_pkg::GrpW-1:0];
        tsc_pkg::CfgMode:           mode_q    <= cfg_data_i[tsc_pkg::ModeW-1:0];
        tsc_pkg::CfgSrcCapacity:    src_cap_q <= cfg_data_i[tsc_pkg::OutW-1:0];
        tsc_pkg::CfgDstCapacity:    dst_cap_q <= cfg_data_i[tsc_pkg::OutW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp block size into 1..MaxTokensPerBlock
  always_comb begin
    if (tpb_q == '0) begin
      tpb_eff = tsc_pkg::CntW'(1);
    end else if (tpb_q > tsc_pkg::TpbW'(tsc_pkg::MaxTokensPerBlock)) begin
      tpb_eff = tsc_pkg::CntW'(tsc_pkg::MaxTokensPerBlock);
    end else begin
      tpb_eff = tsc_pkg::CntW'(tpb_q);
    end
  end

  assign slice = mode_q[tsc_pkg::ModeHalfBit] ? {1'b0, ssb_q[tsc_pkg::BytesW-1:1]} : ssb_q;

  // Tokens left in this block, and descriptors for this item
  assign avail = tpb_eff - base_q;
  assign count = (rem_q < tsc_pkg::TokW'(avail)) ? tsc_pkg::CntW'(rem_q) : avail;

  tsc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (pos_q),
    .divisor_i   (tpb_eff),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .done_o      (div_done)
  );

  assign commit  = cmd_i.emit && (left_q == tsc_pkg::CntW'(1));
  assign pos_sum = {1'b0, pos_q} + (tsc_pkg::TokW + 1)'(cnt_q);

  // Track position, remaining tokens and the block split of the position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      base_q   <= '0;
      div_ok_q <= 1'b0;
    end else begin
      if (cmd_i.load_start) begin
        pos_q    <= start_token_i;
        rem_q    <= token_count_i;
        div_ok_q <= 1'b0;
      end else if (div_done) begin
        quo_q    <= div_quo;
        base_q   <= div_rem;
        div_ok_q <= 1'b1;
      end else if (commit) begin
        pos_q <= pos_sum[tsc_pkg::TokW-1:0];
        rem_q <= rem_q - tsc_pkg::TokW'(cnt_q);
        // A filled block moves on to the next one unless the position wrapped
        if (full_q && !pos_sum[tsc_pkg::TokW]) begin
          quo_q  <= quo_q + 1'b1;
          base_q <= '0;
        end else begin
          div_ok_q <= 1'b0;
        end
      end
      if (cfg_we_i && (cfg_idx_i == tsc_pkg::CfgTokensPerBlock)) begin
        div_ok_q <= 1'b0;
      end
    end
  end

  // Capture the block pair
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_block) begin
      blk_idx_q <= block_index_i;
      sbn_q     <= src_block_number_i;
      dbn_q     <= dst_block_number_i;
    end
  end

  // Select shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      tsc_pkg::MS_SRC_A: begin
        mul_a = tsc_pkg::MulAW'(stb_q);
        mul_b = tsc_pkg::MulBW'(tpb_eff);
      end
      tsc_pkg::MS_SRC_B: begin
        mul_a = sbn_q;
        mul_b = p_q[tsc_pkg::MulBW-1:0];
      end
      tsc_pkg::MS_DST_A: begin
        mul_a = tsc_pkg::MulAW'(dtb_q);
        mul_b = tsc_pkg::MulBW'(tpb_eff);
      end
      tsc_pkg::MS_DST_B: begin
        mul_a = dbn_q;
        mul_b = p_q[tsc_pkg::MulBW-1:0];
      end
      tsc_pkg::MS_SOFF: begin
        mul_a = tsc_pkg::MulAW'(base_q);
        mul_b = tsc_pkg::MulBW'(stb_q);
      end
      tsc_pkg::MS_DOFF: begin
        mul_a = tsc_pkg::MulAW'(base_q);
        mul_b = tsc_pkg::MulBW'(dtb_q);
      end
      tsc_pkg::MS_GRP: begin
        mul_a = tsc_pkg::MulAW'(grp_q);
        mul_b = tsc_pkg::MulBW'(slice);
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Build the base offsets, then step one token per emitted beat
  always_ff @(posedge clk_i) begin
    p_q <= tsc_pkg::AccW'(mul_full);
    case (cmd_i.step)
      tsc_pkg::MS_DST_A: sacc_q <= p_q;
      tsc_pkg::MS_SOFF:  dacc_q <= p_q;
      tsc_pkg::MS_DOFF:  sacc_q <= sacc_q + p_q;
      tsc_pkg::MS_GRP:   dacc_q <= dacc_q + p_q;
      tsc_pkg::MS_FIN:   dacc_q <= dacc_q + p_q;
      default: begin
        if (cmd_i.emit) begin
          sacc_q <= sacc_q + tsc_pkg::AccW'(stb_q);
          dacc_q <= dacc_q + tsc_pkg::AccW'(dtb_q);
        end
      end
    endcase
  end

  // Latch descriptor count, count down beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      cnt_q  <= '0;
      full_q <= 1'b0;
    end else if (cmd_i.step == tsc_pkg::MS_FIN) begin
      left_q <= count;
      cnt_q  <= count;
      full_q <= (count == avail);
    end else if (cmd_i.emit) begin
      left_q <= left_q - 1'b1;
    end
  end

  // Swap sides and check end offsets
  assign so  = mode_q[tsc_pkg::ModeSwapBit] ? dacc_q : sacc_q;
  assign dof = mode_q[tsc_pkg::ModeSwapBit] ? sacc_q : dacc_q;
  assign se  = {1'b0, so}  + tsc_pkg::SumW'(slice);
  assign de  = {1'b0, dof} + tsc_pkg::SumW'(slice);
  assign oob = (se > tsc_pkg::OffMask) || (de > tsc_pkg::OffMask) ||
               (se > tsc_pkg::SumW'(src_cap_q)) || (de > tsc_pkg::SumW'(dst_cap_q));

  // Output register: load on emit, drop when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (desc_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_src_q  <= tsc_pkg::OutW'({1'b0, so} & tsc_pkg::OffMask);
      out_dst_q  <= tsc_pkg::OutW'({1'b0, dof} & tsc_pkg::OffMask);
      out_len_q  <= slice;
      out_oob_q  <= oob;
      out_last_q <= (left_q == tsc_pkg::CntW'(1));
    end
  end

  assign desc_valid_o      = out_valid_q;
  assign copy_src_offset_o = out_src_q;
  assign copy_dst_offset_o = out_dst_q;
  assign copy_length_o     = out_len_q;
  assign out_of_bounds_o   = out_oob_q;
  assign last_o            = out_last_q;

  assign status_o.rem_zero  = (rem_q == '0);
  assign status_o.div_ok    = div_ok_q;
  assign status_o.div_done  = div_done;
  assign status_o.idx_match = (blk_idx_q == quo_q);
  assign status_o.out_free  = !out_valid_q || desc_ready_i;
  assign status_o.last_beat = (left_q == tsc_pkg::CntW'(1));

  // A beat is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || desc_ready_i))
    else $error("descriptor loaded over an untaken beat");

  // Each beat comes from a nonzero descriptor count
  a_emit_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (left_q != '0))
    else $error("descriptor emitted with no count left");

  // The last beat takes exactly the item's count off the remaining tokens
  a_commit_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && !cmd_i.load_start) |=> (rem_q == $past(rem_q) - tsc_pkg::TokW'($past(cnt_q))))
    else $error("remaining token count not advanced by item count");

endmodule

[rtl/tsc_ctrl.sv]
// Controller: sequences request intake, the position divide, the offset setup
// steps and descriptor emission. Depends on tsc_pkg.
module tsc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_type_i,
  output logic             req_ready_o,
  input  tsc_pkg::status_t status_i,
  output tsc_pkg::cmd_t    cmd_o
);

  tsc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '{load_start: 1'b0, load_block: 1'b0, div_start: 1'b0,
                    step: tsc_pkg::MS_NONE, emit: 1'b0};
    case (state_q)
      tsc_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_type_i == tsc_pkg::ReqBlock) begin
            cmd_o.load_block = 1'b1;
            state_d          = tsc_pkg::S_CHECK;
          end else begin
            cmd_o.load_start = 1'b1;
          end
        end
      end
      tsc_pkg::S_CHECK: begin
        if (status_i.rem_zero) begin
          state_d = tsc_pkg::S_IDLE;
        end else if (status_i.div_ok) begin
          state_d = tsc_pkg::S_MATCH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = tsc_pkg::S_DIV;
        end
      end
      tsc_pkg::S_DIV: begin
        if (status_i.div_done) begin
          state_d = tsc_pkg::S_MATCH;
        end
      end
      tsc_pkg::S_MATCH: begin
        state_d = status_i.idx_match ? tsc_pkg::S_SRC_A : tsc_pkg::S_IDLE;
      end
      tsc_pkg::S_SRC_A: begin
        cmd_o.step = tsc_pkg::MS_SRC_A;
        state_d    = tsc_pkg::S_SRC_B;
      end
      tsc_pkg::S_SRC_B: begin
        cmd_o.step = tsc_pkg::MS_SRC_B;
        state_d    = tsc_pkg::S_DST_A;
      end
      tsc_pkg::S_DST_A: begin
        cmd_o.step = tsc_pkg::MS_DST_A;
        state_d    = tsc_pkg::S_DST_B;
      end
      tsc_pkg::S_DST_B: begin
        cmd_o.step = tsc_pkg::MS_DST_B;
        state_d    = tsc_pkg::S_SOFF;
      end
      tsc_pkg::S_SOFF: begin
        cmd_o.step = tsc_pkg::MS_SOFF;
        state_d    = tsc_pkg::S_DOFF;
      end
      tsc_pkg::S_DOFF: begin
        cmd_o.step = tsc_pkg::MS_DOFF;
        state_d    = tsc_pkg::S_GRP;
      end
      tsc_pkg::S_GRP: begin
        cmd_o.step = tsc_pkg::MS_GRP;
        state_d    = tsc_pkg::S_FIN;
      end
      tsc_pkg::S_FIN: begin
        cmd_o.step = tsc_pkg::MS_FIN;
        state_d    = tsc_pkg::S_EMIT;
      end
      tsc_pkg::S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_beat) begin
            state_d = tsc_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = tsc_pkg::S_IDLE;
      end
    endcase
  end

  // A stalled output holds the sequencer in emission
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsc_pkg::S_EMIT && !status_i.out_free) |=> (state_q == tsc_pkg::S_EMIT))
    else $error("left emission while output was stalled");

endmodule

[rtl/per_token_slice_copy_descriptors_unit.sv]
// Top level of the per-token slice copy descriptor unit.
// Depends on tsc_pkg, tsc_if, tsc_ctrl and tsc_dp.
//
// Usage:
//   req_i carries request items. A start item (req_type 0) loads the first
//   token position and token count in one beat and produces nothing. A
//   block-pair item (req_type 1) whose block_index is the block holding the
//   current position produces one descriptor per token on desc_o, up to the
//   end of that block or of the request; last marks its final beat. Other
//   block items produce nothing.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the eight configuration registers;
//   write only while no item is in progress.
// Sequence:
//   A block item passes a check state, a divide of the position when its
//   block is not already known (after a start item or a change of
//   tokens_per_block), a match state and the setup steps on the shared
//   multiplier, then one descriptor per cycle while the output is not
//   stalled: up to tokens_per_block descriptors (at most 64), 16 by default.
//   Following block items of a request skip the divide.
// Reset clears the request state and returns registers to their defaults.
// A stalled receiver holds the output register and the emission sequence;
// the unit takes its next item while the final descriptor waits.
module per_token_slice_copy_descriptors_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tsc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tsc_pkg::CfgW-1:0]    cfg_data_i,
  tsc_req_if.sink                     req_i,
  tsc_desc_if.source                  desc_o
);

  tsc_pkg::cmd_t    cmd;
  tsc_pkg::status_t status;

  tsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tsc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .start_token_i      (req_i.start_token),
    .token_count_i      (req_i.token_count),
    .block_index_i      (req_i.block_index),
    .src_block_number_i (req_i.src_block_number),
    .dst_block_number_i (req_i.dst_block_number),
    .cmd_i              (cmd),
    .status_o           (status),
    .desc_ready_i       (desc_o.ready),
    .desc_valid_o       (desc_o.valid),
    .copy_src_offset_o  (desc_o.copy_src_offset),
    .copy_dst_offset_o  (desc_o.copy_dst_offset),
    .copy_length_o      (desc_o.copy_length),
    .out_of_bounds_o    (desc_o.out_of_bounds),
    .last_o             (desc_o.last)
  );

endmodule
